>>> rtl/core/mao_pkg.sv
// Shared constants, register codes and controller/datapath interface types.
package mao_pkg;

	localparam int CAPACITY   = 16;
	localparam int CAP_BITS   = 4;
	localparam int ROUND_W    = 5;
	localparam int MAGAZINES  = 64;
	localparam int MAG_W      = 6;
	localparam int CNT_W      = 7;
	localparam int SLOT_W     = 10;
	localparam int REQUESTERS = 4;
	localparam int REQ_W      = 2;
	localparam int HANDLE_W   = 32;

	typedef enum logic [1:0] {
		REG_BASE_ADDRESS      = 2'd0,
		REG_OBJECT_SIZE       = 2'd1,
		REG_MAX_OBJECTS       = 2'd2,
		REG_ACTIVE_REQUESTERS = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NO_OBJECT = 2'd1,
		ST_NO_EMPTY  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		PATH_LOADED = 2'd0,
		PATH_SWAP   = 2'd1,
		PATH_DEPOT  = 2'd2
	} path_t;

	typedef enum logic {
		OP_GET = 1'b0,
		OP_PUT = 1'b1
	} op_t;

	typedef struct packed {
		logic winit;
		logic walk;
		logic accept;
		logic rd;
		logic dec;
		logic rdm;
		logic acc;
	} ctrl_cmd_t;

	typedef struct packed {
		logic walk_last;
	} dp_stat_t;

endpackage

>>> rtl/core/magazine_object_allocator.sv
// Top level of the magazine object allocator: controller plus datapath.
//
// channel   direction  signals                                     handshake
// command   in         op, requester, object_handle                start & !busy
// result    out        granted_handle, status, path_taken          done (1 cycle)
// config    in         cfg_index, cfg_wdata                        cfg_we
//
// Each word runs four steps after the accept edge: read the magazine pair, decide,
// read the chosen magazine's rounds, access the slot. done is registered from the
// access step, and the next word is accepted only once done has fallen.
// After reset and after every config write an init walk (one slot per cycle over
// all 1024 slots) runs with busy high.
// The result strobe cannot be stalled; busy stays high until it is shown.
module magazine_object_allocator (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	output logic                         done,
	input  logic                         cfg_we,
	input  logic [1:0]                   cfg_index,
	input  logic [31:0]                  cfg_wdata,
	input  logic                         op,
	input  logic [1:0]                   requester,
	input  logic [mao_pkg::HANDLE_W-1:0] object_handle,
	output logic [mao_pkg::HANDLE_W-1:0] granted_handle,
	output logic [1:0]                   status,
	output logic [1:0]                   path_taken
);
	import mao_pkg::*;

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	mao_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cfg_we (cfg_we),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	mao_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.op             (op),
		.requester      (requester),
		.object_handle  (object_handle),
		.granted_handle (granted_handle),
		.status         (status),
		.path_taken     (path_taken)
	);

endmodule

>>> rtl/core/mao_ctrl.sv
// Controller state machine: init walk sequencing and per-word step order.
module mao_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               cfg_we,
	input  mao_pkg::dp_stat_t  stat,
	output mao_pkg::ctrl_cmd_t cmd,
	output logic               busy,
	output logic               done
);
	import mao_pkg::*;

	typedef enum logic [6:0] {
		S_WINIT = 7'b0000001,
		S_WALK  = 7'b0000010,
		S_IDLE  = 7'b0000100,
		S_RD    = 7'b0001000,
		S_DEC   = 7'b0010000,
		S_RDM   = 7'b0100000,
		S_ACC   = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	logic   done_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_WINIT: state_d = S_WALK;
			S_WALK:  if (stat.walk_last) state_d = S_IDLE;
			S_IDLE:  if (start && !done_q) state_d = S_RD;
			S_RD:    state_d = S_DEC;
			S_DEC:   state_d = S_RDM;
			S_RDM:   state_d = S_ACC;
			S_ACC:   state_d = S_IDLE;
			default: state_d = S_WINIT;
		endcase
		if (cfg_we) state_d = S_WINIT;
	end

	// hold state and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_WINIT;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == S_ACC);
		end
	end

	assign cmd.winit  = (state_q == S_WINIT);
	assign cmd.walk   = (state_q == S_WALK);
	assign cmd.accept = (state_q == S_IDLE) && start && !done_q;
	assign cmd.rd     = (state_q == S_RD);
	assign cmd.dec    = (state_q == S_DEC);
	assign cmd.rdm    = (state_q == S_RDM);
	assign cmd.acc    = (state_q == S_ACC);
	assign busy       = (state_q != S_IDLE) || done_q;
	assign done       = done_q;

endmodule

>>> rtl/core/mao_dp.sv
// Datapath: config registers, magazine memories, depot stacks and result registers.
module mao_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mao_pkg::ctrl_cmd_t            cmd,
	output mao_pkg::dp_stat_t             stat,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_index,
	input  logic [31:0]                   cfg_wdata,
	input  logic                          op,
	input  logic [1:0]                    requester,
	input  logic [mao_pkg::HANDLE_W-1:0]  object_handle,
	output logic [mao_pkg::HANDLE_W-1:0]  granted_handle,
	output logic [1:0]                    status,
	output logic [1:0]                    path_taken
);
	import mao_pkg::*;

	// config registers
	logic [31:0] base_q;
	logic [16:0] size_q;
	logic [10:0] maxobj_q;
	logic [2:0]  nreq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q   <= '0;
			size_q   <= 17'd64;
			maxobj_q <= 11'd128;
			nreq_q   <= 3'd4;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_BASE_ADDRESS:      base_q   <= cfg_wdata;
				REG_OBJECT_SIZE:       size_q   <= cfg_wdata[16:0];
				REG_MAX_OBJECTS:       maxobj_q <= cfg_wdata[10:0];
				REG_ACTIVE_REQUESTERS: nreq_q   <= cfg_wdata[2:0];
				default: ;
			endcase
		end
	end

	// derive live requesters, empty and full magazine counts
	logic [2:0]  n_live;
	logic [7:0]  e_cnt, f_raw, f_cnt, f_cap;
	logic [11:0] obj_sum;

	always_comb begin
		n_live = nreq_q;
		if (n_live == 3'd0) n_live = 3'd1;
		if (n_live > 3'(REQUESTERS)) n_live = 3'(REQUESTERS);
		e_cnt = (n_live == 3'd1) ? 8'd2 : {4'd0, n_live, 1'b0} - 8'd2;
		obj_sum = {1'b0, maxobj_q} + 12'(CAPACITY - 1);
		f_raw = obj_sum[11:CAP_BITS];
		f_cnt = f_raw;
		if (f_cnt < {4'd0, n_live, 1'b0}) f_cnt = {4'd0, n_live, 1'b0};
		f_cap = 8'(MAGAZINES) - e_cnt;
		if (f_cnt > f_cap) f_cnt = f_cap;
	end

	// memories
	logic [HANDLE_W-1:0] slots [MAGAZINES*CAPACITY];
	logic [ROUND_W-1:0]  rounds [MAGAZINES];
	logic [MAG_W-1:0]    full_stack [MAGAZINES];
	logic [MAG_W-1:0]    empty_stack [MAGAZINES];

	logic [MAG_W-1:0]    loaded_q [REQUESTERS];
	logic [MAG_W-1:0]    prev_q [REQUESTERS];
	logic [CNT_W-1:0]    fc_q, ec_q;

	logic [SLOT_W-1:0]   walk_cnt_q;
	logic [HANDLE_W-1:0] walk_h_q;

	logic                op_q;
	logic [REQ_W-1:0]    req_q;
	logic [HANDLE_W-1:0] h_in_q;
	logic [MAG_W-1:0]    m_q;
	logic                fail_q, ok_q;
	logic [1:0]          st_q, path_q;

	logic [ROUND_W-1:0]  rd_a_q, rd_b_q;
	logic [MAG_W-1:0]    ftop_q, etop_q;
	logic [HANDLE_W-1:0] slot_rd_q;

	// walk decode
	logic        walk_slot, walk_round;
	logic [11:0] fill_len;
	logic [MAG_W-1:0] walk_id;
	logic [7:0]  walk_id8;
	logic [SLOT_W-1:0] walk_addr;
	logic [11:0] walk_addr_w;

	always_comb begin
		fill_len    = {f_cnt, 4'd0};
		walk_slot   = {2'b0, walk_cnt_q} < fill_len;
		walk_round  = (walk_cnt_q[SLOT_W-1:MAG_W] == '0);
		walk_id     = walk_cnt_q[MAG_W-1:0];
		walk_id8    = {2'b0, walk_id};
		walk_addr_w = {e_cnt, 4'd0} + {2'b0, walk_cnt_q};
		walk_addr   = walk_addr_w[SLOT_W-1:0];
	end

	assign stat.walk_last = (walk_cnt_q == SLOT_W'(MAGAZINES*CAPACITY - 1));

	// current requester's magazines
	logic [MAG_W-1:0] cur_l, cur_p;
	assign cur_l = loaded_q[req_q];
	assign cur_p = prev_q[req_q];

	// decision on the magazine pair and depot
	logic             d_fail, d_swap, d_depot;
	logic [1:0]       d_st, d_path;
	logic             inactive;
	logic [CNT_W-1:0] full_lim;

	always_comb begin
		full_lim = CNT_W'(MAGAZINES);
		inactive = {1'b0, req_q} >= n_live;
		d_fail = 1'b0; d_swap = 1'b0; d_depot = 1'b0;
		d_st = ST_OK; d_path = PATH_LOADED;
		if (inactive) begin
			d_fail = 1'b1;
			d_st = (op_q == OP_PUT) ? ST_NO_EMPTY : ST_NO_OBJECT;
		end else if (op_q == OP_GET) begin
			if (rd_a_q != '0) begin
				d_path = PATH_LOADED;
			end else if (rd_b_q != '0) begin
				d_swap = 1'b1; d_path = PATH_SWAP;
			end else if (fc_q == '0 || ec_q >= full_lim) begin
				d_fail = 1'b1; d_st = ST_NO_OBJECT;
			end else begin
				d_depot = 1'b1; d_path = PATH_DEPOT;
			end
		end else begin
			if (rd_a_q < ROUND_W'(CAPACITY)) begin
				d_path = PATH_LOADED;
			end else if (rd_b_q < ROUND_W'(CAPACITY)) begin
				d_swap = 1'b1; d_path = PATH_SWAP;
			end else if (ec_q == '0 || fc_q >= full_lim) begin
				d_fail = 1'b1; d_st = ST_NO_EMPTY;
			end else begin
				d_depot = 1'b1; d_path = PATH_DEPOT;
			end
		end
	end

	// rounds memory ports
	logic [MAG_W-1:0]   rnd_addr_a;
	logic               rnd_we;
	logic [MAG_W-1:0]   rnd_waddr;
	logic [ROUND_W-1:0] rnd_wdata;
	logic               acc_get_ok, acc_put_ok;

	always_comb begin
		acc_get_ok = cmd.acc && !fail_q && (op_q == OP_GET) && (rd_a_q != '0);
		acc_put_ok = cmd.acc && !fail_q && (op_q == OP_PUT) &&
			(rd_a_q < ROUND_W'(CAPACITY));
		rnd_addr_a = cmd.rdm ? m_q : cur_l;
		rnd_we = 1'b0; rnd_waddr = m_q; rnd_wdata = rd_a_q;
		if (cmd.walk && walk_round) begin
			rnd_we    = 1'b1;
			rnd_waddr = walk_id;
			rnd_wdata = (walk_id8 >= e_cnt && walk_id8 < e_cnt + f_cnt) ?
				ROUND_W'(CAPACITY) : '0;
		end else if (acc_get_ok) begin
			rnd_we = 1'b1; rnd_wdata = rd_a_q - 1'b1;
		end else if (acc_put_ok) begin
			rnd_we = 1'b1; rnd_wdata = rd_a_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (rnd_we) rounds[rnd_waddr] <= rnd_wdata;
		rd_a_q <= rounds[rnd_addr_a];
		if (cmd.rd) rd_b_q <= rounds[cur_p];
	end

	// slot memory port
	logic                slot_we;
	logic [SLOT_W-1:0]   slot_addr;
	logic [HANDLE_W-1:0] slot_wdata;
	logic [ROUND_W-1:0]  rnd_dec;

	always_comb begin
		rnd_dec    = rd_a_q - 1'b1;
		slot_we    = 1'b0;
		slot_wdata = h_in_q;
		slot_addr  = {m_q, rd_a_q[CAP_BITS-1:0]};
		if (cmd.walk) begin
			slot_we    = walk_slot;
			slot_wdata = walk_h_q;
			slot_addr  = walk_addr;
		end else if (acc_get_ok) begin
			slot_addr = {m_q, rnd_dec[CAP_BITS-1:0]};
		end else if (acc_put_ok) begin
			slot_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (slot_we) slots[slot_addr] <= slot_wdata;
		slot_rd_q <= slots[slot_addr];
	end

	// depot stack memories
	logic [CNT_W-1:0] fc_m1, ec_m1;
	assign fc_m1 = fc_q - 1'b1;
	assign ec_m1 = ec_q - 1'b1;

	always_ff @(posedge clk) begin
		if (cmd.walk && walk_round) begin
			empty_stack[walk_id] <= walk_id;
			full_stack[walk_id]  <= walk_id + e_cnt[MAG_W-1:0];
		end else if (cmd.dec && d_depot && op_q == OP_GET) begin
			empty_stack[ec_q[MAG_W-1:0]] <= cur_l;
		end else if (cmd.dec && d_depot && op_q == OP_PUT) begin
			full_stack[fc_q[MAG_W-1:0]] <= cur_l;
		end
		ftop_q <= full_stack[fc_m1[MAG_W-1:0]];
		etop_q <= empty_stack[ec_m1[MAG_W-1:0]];
	end

	// walk counter, handle accumulator, depot counts and magazine pairs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_cnt_q <= '0;
			fc_q <= '0;
			ec_q <= '0;
			for (int i = 0; i < REQUESTERS; i++) begin
				loaded_q[i] <= '0;
				prev_q[i]   <= '0;
			end
		end else if (cmd.winit) begin
			walk_cnt_q <= '0;
			fc_q <= CNT_W'(f_cnt - {5'd0, n_live});
			ec_q <= CNT_W'(e_cnt - {5'd0, n_live});
			for (int i = 0; i < REQUESTERS; i++) begin
				loaded_q[i] <= MAG_W'(e_cnt + f_cnt - 8'd1 - 8'(i));
				prev_q[i]   <= MAG_W'(e_cnt - 8'd1 - 8'(i));
			end
		end else if (cmd.walk) begin
			walk_cnt_q <= walk_cnt_q + 1'b1;
		end else if (cmd.dec) begin
			if (d_swap) begin
				loaded_q[req_q] <= cur_p;
				prev_q[req_q]   <= cur_l;
			end else if (d_depot && op_q == OP_GET) begin
				loaded_q[req_q] <= ftop_q;
				fc_q <= fc_m1;
				ec_q <= ec_q + 1'b1;
			end else if (d_depot) begin
				loaded_q[req_q] <= etop_q;
				ec_q <= ec_m1;
				fc_q <= fc_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.winit) walk_h_q <= base_q;
		else if (cmd.walk) walk_h_q <= walk_h_q + {15'd0, size_q};
	end

	// capture the word and track its result
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q   <= op;
			req_q  <= requester;
			h_in_q <= object_handle;
		end
		if (cmd.dec) begin
			fail_q <= d_fail;
			st_q   <= d_st;
			path_q <= d_path;
			if (d_swap) m_q <= cur_p;
			else if (d_depot) m_q <= (op_q == OP_GET) ? ftop_q : etop_q;
			else m_q <= cur_l;
		end
		if (cmd.acc) begin
			ok_q <= acc_get_ok || acc_put_ok;
			if (!fail_q && !acc_get_ok && !acc_put_ok) begin
				st_q   <= (op_q == OP_PUT) ? ST_NO_EMPTY : ST_NO_OBJECT;
				path_q <= PATH_LOADED;
			end
		end
	end

	assign granted_handle = (ok_q && op_q == OP_GET) ? slot_rd_q : '0;
	assign status         = st_q;
	assign path_taken     = path_q;

endmodule
